// ===== design/csem_pkg.sv =====
// ----------------------------------------------------------------------------
// csem_pkg
// shared types and constants of the csr edge sample mapper
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_EDGES    = 65536;
    localparam int BATCH_DEPTH  = 64;

    localparam int VTX_AW = $clog2(MAX_VERTICES);
    localparam int EDG_AW = $clog2(MAX_EDGES);
    localparam int BUF_AW = $clog2(BATCH_DEPTH);
    localparam int CNT_W  = BUF_AW + 1;

    // transaction actions
    localparam logic [1:0] ACT_WR_OFFSET    = 2'd0;
    localparam logic [1:0] ACT_WR_NEIGHBOUR = 2'd1;
    localparam logic [1:0] ACT_PUSH_SAMPLE  = 2'd2;
    localparam logic [1:0] ACT_RESERVED     = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_NUM_VERTICES = 3'd0;
    localparam logic [2:0] ADDR_NUM_EDGES    = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] table_address;
        logic [16:0] table_value;
        logic [15:0] sample_index;
        logic        last_sample;
    } t_in_item;

    typedef struct packed {
        logic [11:0] source_vertex;
        logic [11:0] target_vertex;
        logic        out_of_range;
        logic        last_result;
    } t_out_item;

endpackage

// ===== design/csr_edge_sample_mapper_core.sv =====
// ----------------------------------------------------------------------------
// csr_edge_sample_mapper_core
// maps a batch of sampled edge indices to (source, target) vertex pairs
// ----------------------------------------------------------------------------
// Table loads (offset or neighbour entry) are written while idle. A sample
// push goes into the sorted batch buffer by an insertion step: S_INS_CHK
// reads the entry below the hole, S_INS_CMP shifts it up or places the new
// index; the registered buffer read sets this pair of states. When a push
// carries last_sample, or fills the 64-entry batch, the block walks the
// sorted batch against the offset table: each result reads its index, then
// waits for an offset read and compares for every offset entry the cursor
// steps over, as the offset read is registered. Results leave through an
// output register in ascending index order; the final one carries
// last_result. The input side is not ready while a push or a batch walk is
// in progress. Offset entry 0 is never read and counts as 0.
// ----------------------------------------------------------------------------
module csr_edge_sample_mapper_core
    import csem_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // apb-style register port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    // input transactions
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_data,
    // result transactions
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CHK  = 3'd1;  // issue read of the entry below
    localparam logic [2:0] S_INS_CMP  = 3'd2;  // compare, shift up or place
    localparam logic [2:0] S_FL_BUF   = 3'd3;  // issue read of sorted entry k
    localparam logic [2:0] S_FL_EGET  = 3'd4;  // capture index
    localparam logic [2:0] S_FL_OFFRD = 3'd5;  // wait for offset read
    localparam logic [2:0] S_FL_CMP   = 3'd6;  // advance cursor or resolve
    localparam logic [2:0] S_FL_EMIT  = 3'd7;  // hand result to output register

    localparam logic [VTX_AW:0] NV_MAX = (VTX_AW+1)'(MAX_VERTICES);
    localparam logic [EDG_AW:0] NE_MAX = (EDG_AW+1)'(MAX_EDGES);
    localparam logic [CNT_W-1:0] BATCH_FULL = CNT_W'(BATCH_DEPTH);

    // configuration registers
    logic [12:0] r_num_vertices;
    logic [16:0] r_num_edges;

    // memories
    logic [16:0] offset_mem    [MAX_VERTICES];
    logic [11:0] neighbour_mem [MAX_EDGES];
    logic [15:0] sample_mem    [BATCH_DEPTH];

    logic [16:0] r_off_rd;
    logic [11:0] r_nb_rd;
    logic [15:0] r_buf_rd;

    // sequencer registers
    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;     // entries held in the batch
    logic [BUF_AW-1:0] r_j;         // insertion hole
    logic [15:0]       r_v;         // value being inserted
    logic              r_last;
    logic [BUF_AW-1:0] r_k;         // walk position in the batch
    logic [15:0]       r_e;         // index under the walk
    logic [VTX_AW:0]   r_cur;       // offset walk cursor
    logic              r_ov;
    t_out_item         r_out;

    logic [BUF_AW-1:0] buf_raddr;
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [15:0]       buf_wdata;
    logic              in_acc;
    logic              out_free;
    logic [VTX_AW:0]   nv_eff;
    logic [EDG_AW:0]   ne_eff;
    logic [CNT_W-1:0]  count_inc;
    logic              ins_done;
    logic              advance;
    logic              in_range;
    logic              is_last;
    logic              cfg_wr;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= 13'd1;
            r_num_edges    <= 17'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == ADDR_NUM_EDGES[2]) begin
                r_num_edges <= pwdata[16:0];
            end else begin
                r_num_vertices <= pwdata[12:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ADDR_NUM_EDGES[2]) begin
            prdata = {15'd0, r_num_edges};
        end else begin
            prdata = {19'd0, r_num_vertices};
        end
    end

    // registers above the table size count as the table size
    assign nv_eff = (r_num_vertices > NV_MAX) ? NV_MAX : r_num_vertices;
    assign ne_eff = (r_num_edges > NE_MAX) ? NE_MAX : r_num_edges;

    // ---------------- handshakes ----------------
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.action == ACT_WR_OFFSET
                && i_in_data.table_address < 16'(MAX_VERTICES)) begin
            offset_mem[i_in_data.table_address[VTX_AW-1:0]] <= i_in_data.table_value;
        end
        r_off_rd <= offset_mem[r_cur[VTX_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.action == ACT_WR_NEIGHBOUR) begin
            neighbour_mem[i_in_data.table_address[EDG_AW-1:0]] <=
                i_in_data.table_value[11:0];
        end
        r_nb_rd <= neighbour_mem[r_e[EDG_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            sample_mem[buf_waddr] <= buf_wdata;
        end
        r_buf_rd <= sample_mem[buf_raddr];
    end

    // ---------------- datapath decisions ----------------
    assign buf_raddr = (r_state == S_INS_CHK) ? (r_j - 1'b1) : r_k;
    assign count_inc = r_count + 1'b1;
    assign advance   = (r_cur < nv_eff) && ({1'b0, r_e} >= r_off_rd);
    assign in_range  = ({1'b0, r_e} < ne_eff);
    assign is_last   = ({1'b0, r_k} + 1'b1) == r_count;

    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = r_j;
        buf_wdata = r_v;
        ins_done  = 1'b0;
        if (r_state == S_INS_CHK && r_j == '0) begin
            buf_we   = 1'b1;
            ins_done = 1'b1;
        end else if (r_state == S_INS_CMP) begin
            buf_we = 1'b1;
            if (r_buf_rd > r_v) begin
                buf_wdata = r_buf_rd;     // shift the larger entry up
            end else begin
                ins_done = 1'b1;          // hole found
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            // a result handed over in the emit state keeps the register full
            if (r_ov && i_out_ready && r_state != S_FL_EMIT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.action == ACT_PUSH_SAMPLE) begin
                        r_v     <= i_in_data.sample_index;
                        r_last  <= i_in_data.last_sample;
                        r_j     <= r_count[BUF_AW-1:0];
                        r_state <= S_INS_CHK;
                    end
                end
                S_INS_CHK, S_INS_CMP: begin
                    if (ins_done) begin
                        r_count <= count_inc;
                        if (r_last || count_inc == BATCH_FULL) begin
                            r_k     <= '0;
                            r_cur   <= (VTX_AW+1)'(1);
                            r_state <= S_FL_BUF;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_state == S_INS_CHK) begin
                        r_state <= S_INS_CMP;
                    end else begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_INS_CHK;
                    end
                end
                S_FL_BUF: begin
                    r_state <= S_FL_EGET;
                end
                S_FL_EGET: begin
                    r_e     <= r_buf_rd;
                    r_state <= S_FL_OFFRD;
                end
                S_FL_OFFRD: begin
                    r_state <= S_FL_CMP;
                end
                S_FL_CMP: begin
                    if (advance) begin
                        r_cur   <= r_cur + 1'b1;
                        r_state <= S_FL_OFFRD;
                    end else begin
                        r_state <= S_FL_EMIT;
                    end
                end
                S_FL_EMIT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out.source_vertex <= in_range ? 12'(r_cur - 1'b1) : 12'd0;
                        r_out.target_vertex <= in_range ? r_nb_rd : 12'd0;
                        r_out.out_of_range  <= !in_range;
                        r_out.last_result   <= is_last;
                        if (is_last) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_FL_BUF;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
